// ===== sv/rmsp_pkg.sv =====
// rmsp_pkg: shared constants, register codes and cell payload types
// for the rmsprop weight update block; no dependencies
`default_nettype none

package rmsp_pkg;

  // cache geometry
  localparam int CACHE_DEPTH = 1024;
  localparam int CacheAw     = $clog2(CACHE_DEPTH);

  // field and datapath widths
  localparam int IdxW    = 10;
  localparam int WordW   = 32;
  localparam int DecW    = 16;
  localparam int CacheW  = 48;
  localparam int GsqW    = 47;
  localparam int RootW   = CacheW / 2;
  localparam int SqRemW  = RootW + 2;
  localparam int NumW    = 64;
  localparam int QW      = 34;
  localparam int NumHiW  = NumW - QW;
  localparam int DenW    = 33;
  localparam int DivW    = DenW + 8;

  // register reset values
  localparam logic [WordW-1:0] LR_RST    = 32'd16777;
  localparam logic [DecW-1:0]  DECAY_RST = 16'd58982;
  localparam logic [WordW-1:0] EPS_RST   = 32'd1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LR    = 2'd0,
    REG_DECAY = 2'd1,
    REG_EPS   = 2'd2
  } cfg_reg_t;

  // fields that ride along with an element through the cells
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] w;
    logic             neg;
  } side_t;

  // square root cell payload
  typedef struct packed {
    logic              vld;
    side_t             side;
    logic [NumW-1:0]   num;
    logic [CacheW-1:0] rad;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
  } sqrt_t;

  // divider cell payload
  typedef struct packed {
    logic            vld;
    side_t           side;
    logic            sat;
    logic [DivW-1:0] dsor;
    logic [DivW-1:0] rem;
    logic [QW-1:0]   nlo;
    logic [QW-1:0]   quo;
  } div_t;

endpackage

`default_nettype wire

// ===== sv/rmsprop_weight_update.sv =====
// rmsprop_weight_update: top level with cache update, root and divider chains
// depends on rmsp_pkg, rmsp_sqrt_cell, rmsp_div_cell
//
//   port group  direction  handshake             payload
//   in_         in         in_valid / in_stall   in_elem_index, in_weight_in, in_grad_in
//   out_        out        out_valid / out_stall out_elem_index_out, out_weight_out
//   cfg_        in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one element per cycle while in_stall is low; from transfer to result an element passes
// 3 cache update stages, 24 root cells, a denominator stage, 34 divider cells and
// the output register; the cache read-modify-write is closed in one stage
// with forwarding from the two stages behind it
// after reset the cache is cleared one entry a cycle, all 1024 entries, with in_stall high
// an output stall is absorbed by a one-entry skid; the chain freezes when it fills
`default_nettype none

module rmsprop_weight_update import rmsp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IdxW-1:0]         in_elem_index,
  input  logic signed [WordW-1:0] in_weight_in,
  input  logic signed [WordW-1:0] in_grad_in,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IdxW-1:0]         out_elem_index_out,
  output logic signed [WordW-1:0] out_weight_out,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [WordW-1:0]        cfg_data
);

  // configuration registers
  logic [WordW-1:0] lr_r;
  logic [DecW-1:0]  decay_r;
  logic [WordW-1:0] eps_r;

  // flow control and cache clear
  logic               en;
  logic               acc_in;
  logic               clr_r;
  logic [CacheAw-1:0] clr_cnt_r;

  // cache memory
  logic [CacheW-1:0] cache_mem [CACHE_DEPTH];
  logic [CacheW-1:0] rd_r;

  // stage 1
  logic             s1_vld_r;
  side_t            s1_side_r;
  logic             s1_rng_r;
  logic [WordW-1:0] s1_mag_r;
  logic [WordW-1:0] g_u;
  logic [NumW-1:0]  sq_full;

  // stage 2
  logic              s2_vld_r;
  side_t             s2_side_r;
  logic              s2_rng_r;
  logic [GsqW-1:0]   s2_gsq_r;
  logic [NumW-1:0]   s2_num_r;
  logic [CacheW-1:0] s2_c_r;
  logic [CacheW-1:0] c_sel;
  logic [DecW:0]     wd;
  logic signed [CacheW:0]   diff;
  logic signed [CacheW+18:0] prod;
  logic signed [CacheW+18:0] tot;
  logic [CacheW-1:0] cn;

  // stage 3 and forwarding stage
  logic              s3_vld_r;
  side_t             s3_side_r;
  logic              s3_rng_r;
  logic [CacheW-1:0] s3_cn_r;
  logic [NumW-1:0]   s3_num_r;
  logic              fw_vld_r;
  logic [IdxW-1:0]   fw_idx_r;
  logic [CacheW-1:0] fw_cn_r;

  // chains
  sqrt_t sq [RootW+1];
  div_t  dv [QW+1];
  div_t  dv_nxt;
  div_t  dv0_r;
  logic  dv0_vld_r;
  logic [DenW-1:0] den;

  // result and output
  logic signed [WordW+3:0] rs;
  logic [WordW-1:0]        res;
  logic                    out_vld_r;
  logic                    skid_vld_r;
  logic [IdxW-1:0]         out_idx_r;
  logic [WordW-1:0]        out_w_r;
  logic [IdxW-1:0]         skid_idx_r;
  logic [WordW-1:0]        skid_w_r;

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r | clr_r;
  assign acc_in   = in_valid & !in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= LR_RST;
      decay_r <= DECAY_RST;
      eps_r   <= EPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LR:    lr_r    <= cfg_data;
        REG_DECAY: decay_r <= cfg_data[DecW-1:0];
        REG_EPS:   eps_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // cache clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CacheAw'(CACHE_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // cache port: read on transfer, write back from stage 2 or clear
  always_ff @(posedge clk) begin
    if (clr_r) begin
      cache_mem[clr_cnt_r] <= '0;
    end else if (en && s2_vld_r && s2_rng_r) begin
      cache_mem[s2_side_r.idx[CacheAw-1:0]] <= cn;
    end
    if (en) begin
      rd_r <= cache_mem[in_elem_index[CacheAw-1:0]];
    end
  end

  // stage 1: capture, gradient magnitude
  assign g_u = in_grad_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= acc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r.idx <= in_elem_index;
      s1_side_r.w   <= in_weight_in;
      s1_side_r.neg <= g_u[WordW-1];
      s1_rng_r      <= (32'(in_elem_index) < CACHE_DEPTH);
      s1_mag_r      <= g_u[WordW-1] ? (~g_u + 32'd1) : g_u;
    end
  end

  // stage 2: gradient square and numerator
  assign sq_full = s1_mag_r * s1_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r <= s1_side_r;
      s2_rng_r  <= s1_rng_r;
      s2_gsq_r  <= sq_full[NumW-2:16];
      s2_num_r  <= lr_r * s1_mag_r;
      s2_c_r    <= rd_r;
    end
  end

  // average update with forwarding from the two newer writes
  always_comb begin
    if (!s2_rng_r) begin
      c_sel = '0;
    end else if (s3_vld_r && s3_rng_r && (s3_side_r.idx == s2_side_r.idx)) begin
      c_sel = s3_cn_r;
    end else if (fw_vld_r && (fw_idx_r == s2_side_r.idx)) begin
      c_sel = fw_cn_r;
    end else begin
      c_sel = s2_c_r;
    end
    wd   = 17'h10000 - {1'b0, decay_r};
    diff = $signed({2'b00, s2_gsq_r}) - $signed({1'b0, c_sel});
    prod = $signed({1'b0, wd}) * diff;
    tot  = $signed({3'b000, c_sel, 16'h0000}) + prod;
    cn   = tot[NumW-1:16];
  end

  // stage 3 and forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      fw_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
      fw_vld_r <= s3_vld_r & s3_rng_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s2_side_r;
      s3_rng_r  <= s2_rng_r;
      s3_cn_r   <= cn;
      s3_num_r  <= s2_num_r;
      fw_idx_r  <= s3_side_r.idx;
      fw_cn_r   <= s3_cn_r;
    end
  end

  // square root chain
  always_comb begin
    sq[0].vld  = s3_vld_r;
    sq[0].side = s3_side_r;
    sq[0].num  = s3_num_r;
    sq[0].rad  = s3_cn_r;
    sq[0].rem  = '0;
    sq[0].root = '0;
  end

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    rmsp_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (sq[i]),
      .d_o   (sq[i+1])
    );
  end

  // denominator, saturation check and divider setup
  always_comb begin
    den = {9'd0, sq[RootW].root} + {1'b0, eps_r};
    if (den == '0) begin
      den = DenW'(1);
    end
    dv_nxt.vld  = sq[RootW].vld;
    dv_nxt.side = sq[RootW].side;
    dv_nxt.dsor = {den, 8'h00};
    dv_nxt.rem  = {11'd0, sq[RootW].num[NumW-1:QW]};
    dv_nxt.sat  = ({11'd0, sq[RootW].num[NumW-1:QW]} >= {den, 8'h00});
    dv_nxt.nlo  = sq[RootW].num[QW-1:0];
    dv_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv0_vld_r <= 1'b0;
    end else if (en) begin
      dv0_vld_r <= dv_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv0_r <= dv_nxt;
    end
  end

  always_comb begin
    dv[0]     = dv0_r;
    dv[0].vld = dv0_vld_r;
  end

  // divider chain
  for (genvar j = 0; j < QW; j++) begin : g_div
    rmsp_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (dv[j]),
      .d_o   (dv[j+1])
    );
  end

  // apply the step and saturate
  always_comb begin
    if (dv[QW].side.neg) begin
      rs = $signed({{4{dv[QW].side.w[WordW-1]}}, dv[QW].side.w}) + $signed({2'b00, dv[QW].quo});
    end else begin
      rs = $signed({{4{dv[QW].side.w[WordW-1]}}, dv[QW].side.w}) - $signed({2'b00, dv[QW].quo});
    end
    if (dv[QW].sat) begin
      res = dv[QW].side.neg ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else if (rs > 36'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (rs < -36'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = rs[WordW-1:0];
    end
  end

  // output register and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (!out_stall) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r <= dv[QW].vld;
    end else if (dv[QW].vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output register and skid payload
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (!out_stall) begin
        out_idx_r <= skid_idx_r;
        out_w_r   <= skid_w_r;
      end
    end else if (!out_vld_r || !out_stall) begin
      out_idx_r <= dv[QW].side.idx;
      out_w_r   <= res;
    end else begin
      skid_idx_r <= dv[QW].side.idx;
      skid_w_r   <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_elem_index_out = out_idx_r;
  assign out_weight_out     = out_w_r;

  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds data while output register is empty");

  // a frozen chain keeps its last stage
  a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && $past(rst_n)) |=> $stable(dv[QW].vld))
    else $error("last chain stage moved while frozen");

  // clearing pass ends after a full sweep
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_r) |-> (clr_cnt_r == '0))
    else $error("cache clear ended before a full sweep");

endmodule

`default_nettype wire

// ===== sv/rmsp_sqrt_cell.sv =====
// rmsp_sqrt_cell: one root bit of the digit-by-digit integer square root
// depends on rmsp_pkg
`default_nettype none

module rmsp_sqrt_cell import rmsp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  sqrt_t d_i,
  output sqrt_t d_o
);

  logic [SqRemW+1:0] acc;
  logic [SqRemW+1:0] trial;
  logic              fit;
  sqrt_t             nxt;
  sqrt_t             dat_r;
  logic              vld_r;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    acc   = {d_i.rem, d_i.rad[CacheW-1 -: 2]};
    trial = {2'b00, d_i.root, 2'b01};
    fit   = (acc >= trial);
    nxt   = d_i;
    nxt.rad  = {d_i.rad[CacheW-3:0], 2'b00};
    nxt.root = {d_i.root[RootW-2:0], fit};
    nxt.rem  = fit ? SqRemW'(acc - trial) : SqRemW'(acc);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= nxt;
    end
  end

  always_comb begin
    d_o     = dat_r;
    d_o.vld = vld_r;
  end

endmodule

`default_nettype wire

// ===== sv/rmsp_div_cell.sv =====
// rmsp_div_cell: one quotient bit of the restoring divider
// depends on rmsp_pkg
`default_nettype none

module rmsp_div_cell import rmsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  div_t d_i,
  output div_t d_o
);

  logic [DivW:0] acc;
  logic          fit;
  div_t          nxt;
  div_t          dat_r;
  logic          vld_r;

  // shift in the next dividend bit and subtract where the divisor fits
  always_comb begin
    acc = {d_i.rem, d_i.nlo[QW-1]};
    fit = (acc >= {1'b0, d_i.dsor});
    nxt = d_i;
    nxt.nlo = {d_i.nlo[QW-2:0], 1'b0};
    nxt.quo = {d_i.quo[QW-2:0], fit};
    nxt.rem = fit ? DivW'(acc - {1'b0, d_i.dsor}) : DivW'(acc);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= nxt;
    end
  end

  always_comb begin
    d_o     = dat_r;
    d_o.vld = vld_r;
  end

endmodule

`default_nettype wire

// ===== tb/sv/rmsprop_weight_update_tb.sv =====
// rmsprop_weight_update_tb: self-checking bench for the rmsprop weight update block
// depends on rmsp_pkg and rmsprop_weight_update; predicts each updated weight
`timescale 1ns / 100ps

// keeps the squared-gradient averages and settings, and holds expected results
class rmsp_scoreboard;
  logic [47:0] avg_cache[1024];
  logic [31:0] lr;
  logic [15:0] decay;
  logic [31:0] eps;
  logic [9:0]  exp_idx[$];
  logic [31:0] exp_weight[$];
  int          errors;
  int          checked;

  function new();
    foreach (avg_cache[i]) avg_cache[i] = '0;
    lr = rmsp_pkg::LR_RST;
    decay = rmsp_pkg::DECAY_RST;
    eps = rmsp_pkg::EPS_RST;
    errors = 0;
    checked = 0;
  endfunction

  function void write_reg(rmsp_pkg::cfg_reg_t idx, logic [31:0] data);
    case (idx)
      rmsp_pkg::REG_LR:    lr = data;
      rmsp_pkg::REG_DECAY: decay = data[15:0];
      rmsp_pkg::REG_EPS:   eps = data;
      default: ;
    endcase
  endfunction

  // bitwise integer square root, floor
  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // note an accepted input and predict its updated weight
  function void note_input(logic [9:0] idx, logic signed [31:0] w, logic signed [31:0] g);
    logic [63:0]  mag;
    logic [63:0]  gsq;
    logic [127:0] acc;
    logic [47:0]  cn;
    logic [63:0]  den;
    logic [127:0] delta;
    logic signed [65:0] res;
    mag = g[31] ? 64'(-$signed(65'(g))) : 64'(g);
    gsq = (mag * mag) >> 16;
    acc = 128'(decay) * 128'(avg_cache[idx]) + 128'(17'd65536 - decay) * 128'(gsq);
    cn = 48'(acc >> 16);
    avg_cache[idx] = cn;
    den = int_sqrt(64'(cn)) + 64'(eps);
    if (den == 0) den = 1;
    delta = (128'(lr) * 128'(mag)) / (128'(den) << 8);
    if (g[31]) res = 66'(w) + $signed({1'b0, delta[64:0]});
    else res = 66'(w) - $signed({1'b0, delta[64:0]});
    if (res > 66'sd2147483647) res = 66'sd2147483647;
    if (res < -66'sd2147483648) res = -66'sd2147483648;
    exp_idx.push_back(idx);
    exp_weight.push_back(res[31:0]);
  endfunction

  // compare a result against the oldest expectation
  function void check_result(logic [9:0] idx, logic [31:0] w);
    logic [9:0]  ei;
    logic [31:0] ew;
    if (exp_idx.size() == 0) begin
      $error("result with no expectation: elem_index_out %0d", idx);
      errors++;
      return;
    end
    ei = exp_idx.pop_front();
    ew = exp_weight.pop_front();
    checked++;
    if (ei !== idx) begin
      $error("elem_index_out expected %0d actual %0d", ei, idx);
      errors++;
    end
    if (ew !== w) begin
      $error("weight_out expected %h actual %h", ew, w);
      errors++;
    end
  endfunction
endclass

module rmsprop_weight_update_tb;
  import rmsp_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [IdxW-1:0] in_elem_index = '0;
  logic signed [WordW-1:0] in_weight_in = '0;
  logic signed [WordW-1:0] in_grad_in = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [IdxW-1:0] out_elem_index_out;
  logic signed [WordW-1:0] out_weight_out;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [WordW-1:0] cfg_data = '0;

  rmsp_scoreboard sb;
  int send_idle_pct;
  int stall_pct;

  rmsprop_weight_update dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // random receiver stall, sampled and checked at each edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_elem_index_out, out_weight_out);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one input transfer, with random idle cycles before it
  task automatic send_item(logic [9:0] idx, logic [31:0] w, logic [31:0] g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_elem_index <= idx;
    in_weight_in <= w;
    in_grad_in <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(idx, w, g);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // let every expected result drain, then the pipeline settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.exp_idx.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // random gradient: mostly moderate, sometimes any word
  function automatic logic [31:0] rand_grad();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      2: return 32'($signed($urandom_range(1 << 16)) - (1 << 15));
      default: return {{8{1'($urandom_range(1))}}, 24'($urandom())};
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_item(($urandom_range(3) == 0) ? 10'($urandom()) : 10'($urandom_range(15)),
                         $urandom(), rand_grad());
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes at reset settings
    send_item(10'd0, 32'h0000_0000, 32'h0000_0000);
    send_item(10'd1023, 32'h7fff_ffff, 32'h8000_0000);
    send_item(10'd1023, 32'h8000_0000, 32'h7fff_ffff);
    send_item(10'd5, 32'h8000_0000, 32'h8000_0000);
    send_item(10'd5, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(10'd5, 32'h0100_0000, 32'h0000_0001);
    send_item(10'd2, 32'hff00_0000, 32'h0100_0000);
    drain();
    // zero denominator: epsilon of zero with a cleared entry
    write_reg(REG_EPS, 32'd0);
    write_reg(REG_LR, 32'hffff_ffff);
    send_item(10'd700, 32'h1234_5678, 32'h0000_0000);
    send_item(10'd701, 32'h0000_0000, 32'h0000_0001);
    send_item(10'd701, 32'h7fff_0000, 32'h8000_0000);
    drain();
    write_reg(REG_DECAY, 16'd0);
    write_reg(REG_EPS, 32'hffff_ffff);
    send_item(10'd3, 32'h0000_0000, 32'h7fff_ffff);
    send_item(10'd3, 32'h0000_0000, 32'h8000_0001);
    drain();
    write_reg(REG_DECAY, 16'hffff);
    write_reg(REG_LR, 32'd0);
    send_item(10'd3, 32'h5555_5555, 32'h7fff_ffff);
    drain();

    // random phases across settings and idling mixes
    write_reg(REG_LR, LR_RST);
    write_reg(REG_DECAY, DECAY_RST);
    write_reg(REG_EPS, EPS_RST);
    random_phase(300, 0, 0);
    write_reg(REG_LR, $urandom());
    write_reg(REG_DECAY, $urandom());
    write_reg(REG_EPS, $urandom_range(1, 65536));
    random_phase(300, 51, 0);
    write_reg(REG_LR, 32'hffff_ffff);
    write_reg(REG_DECAY, 16'd1);
    write_reg(REG_EPS, 32'd0);
    random_phase(300, 0, 51);
    write_reg(REG_LR, $urandom());
    write_reg(REG_DECAY, 16'hfffe);
    write_reg(REG_EPS, $urandom());
    random_phase(350, 36, 36);

    $display("checked %0d results over extreme fields, zero denominators and four idling mixes",
             sb.checked);
    if (sb.errors == 0 && sb.exp_idx.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule
